// ===== rtl/pee_pkg.sv =====
// ============================================================================
// pee_pkg: shared types and constants of the prefix expression evaluator
// Holds the character codes, the status codes, the operation decode and the
// result bundle passed from the arithmetic unit to the sequencer.
// ============================================================================
`default_nettype none

package pee_pkg;

    // Default operand stack depth
    localparam int STACK_DEPTH_DEF = 64;

    // Field widths
    localparam int CHAR_W      = 8;
    localparam int VALUE_W     = 32;
    localparam int STATUS_W    = 3;
    localparam int OUT_TDATA_W = 40;
    localparam int OUT_PAD_W   = OUT_TDATA_W - VALUE_W - STATUS_W;

    // Iterations of the restoring divider
    localparam int DIV_STEPS = 32;
    localparam int STEP_W    = $clog2(DIV_STEPS + 1);

    // Character codes
    localparam logic [CHAR_W-1:0] CH_PLUS  = 8'h2B;
    localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2D;
    localparam logic [CHAR_W-1:0] CH_STAR  = 8'h2A;
    localparam logic [CHAR_W-1:0] CH_SLASH = 8'h2F;
    localparam logic [CHAR_W-1:0] CH_CARET = 8'h5E;
    localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
    localparam logic [CHAR_W-1:0] CH_NINE  = 8'h39;

    // Result status codes
    localparam logic [STATUS_W-1:0] STAT_OK       = 3'd0;
    localparam logic [STATUS_W-1:0] STAT_FEW      = 3'd1;
    localparam logic [STATUS_W-1:0] STAT_COUNT    = 3'd2;
    localparam logic [STATUS_W-1:0] STAT_DIVZERO  = 3'd3;
    localparam logic [STATUS_W-1:0] STAT_OVERFLOW = 3'd4;

    typedef enum logic [2:0] {
        OP_NONE,
        OP_DIGIT,
        OP_ADD,
        OP_SUB,
        OP_MUL,
        OP_DIV,
        OP_POW
    } op_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_READ,
        S_EXEC,
        S_EMIT
    } state_t;

    typedef struct packed {
        logic               done;
        logic               div_zero;
        logic [VALUE_W-1:0] result;
    } alu_res_t;

    function automatic op_t decode_char(input logic [CHAR_W-1:0] c);
        op_t op;
        op = OP_NONE;
        if (c >= CH_ZERO && c <= CH_NINE)
            op = OP_DIGIT;
        else if (c == CH_PLUS)
            op = OP_ADD;
        else if (c == CH_MINUS)
            op = OP_SUB;
        else if (c == CH_STAR)
            op = OP_MUL;
        else if (c == CH_SLASH)
            op = OP_DIV;
        else if (c == CH_CARET)
            op = OP_POW;
        return op;
    endfunction

    function automatic logic is_binop(input op_t op);
        return (op == OP_ADD) || (op == OP_SUB) || (op == OP_MUL) ||
               (op == OP_DIV) || (op == OP_POW);
    endfunction

endpackage

`default_nettype wire

// ===== rtl/pee_stack_ram.sv =====
// ============================================================================
// pee_stack_ram: operand stack storage
// Single write port, single read port, read data registered.
// ============================================================================
`default_nettype none

module pee_stack_ram
    import pee_pkg::*;
#(
    parameter int DEPTH  = STACK_DEPTH_DEF,
    parameter int ADDR_W = $clog2(STACK_DEPTH_DEF)
)
(
    input  wire logic               clk,
    input  wire logic               wr_en,
    input  wire logic [ADDR_W-1:0]  wr_addr,
    input  wire logic [VALUE_W-1:0] wr_data,
    input  wire logic               rd_en,
    input  wire logic [ADDR_W-1:0]  rd_addr,
    output      logic [VALUE_W-1:0] rd_data
);

    logic [VALUE_W-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

// ===== rtl/pee_alu.sv =====
// ============================================================================
// pee_alu: arithmetic unit of the evaluator
// Add, subtract and multiply need no loop; divide runs a restoring
// loop of one quotient bit per cycle; power runs square-and-multiply, one
// exponent bit per cycle. done pulses for one cycle with the result.
// ============================================================================
`default_nettype none

module pee_alu
    import pee_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               start,
    input  wire op_t                op,
    input  wire logic [VALUE_W-1:0] a,
    input  wire logic [VALUE_W-1:0] b,
    output      alu_res_t           res
);

    logic               busy_reg, busy_next;
    logic               done_reg, done_next;
    logic               dz_reg, dz_next;
    logic               neg_reg, neg_next;
    op_t                op_reg, op_next;
    logic [STEP_W-1:0]  step_reg, step_next;
    logic [VALUE_W-1:0] acc_reg, acc_next;
    logic [VALUE_W-1:0] base_reg, base_next;
    logic [VALUE_W-1:0] aux_reg, aux_next;

    logic [VALUE_W-1:0] mul_ab;
    logic [VALUE_W-1:0] mul_acc;
    logic [VALUE_W-1:0] mul_base;
    logic [VALUE_W:0]   rem_sh;
    logic [VALUE_W:0]   rem_diff;

    // Low halves only: everything wraps modulo 2^32
    assign mul_ab   = a * b;
    assign mul_acc  = acc_reg * base_reg;
    assign mul_base = base_reg * base_reg;

    assign rem_sh   = {base_reg, acc_reg[VALUE_W-1]};
    assign rem_diff = rem_sh - {1'b0, aux_reg};

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        dz_next   = dz_reg;
        neg_next  = neg_reg;
        op_next   = op_reg;
        step_next = step_reg;
        acc_next  = acc_reg;
        base_next = base_reg;
        aux_next  = aux_reg;

        if (start)
        begin
            dz_next = 1'b0;
            op_next = op;
            case (op)
                OP_ADD:
                begin
                    acc_next  = a + b;
                    done_next = 1'b1;
                end
                OP_SUB:
                begin
                    acc_next  = a - b;
                    done_next = 1'b1;
                end
                OP_MUL:
                begin
                    acc_next  = mul_ab;
                    done_next = 1'b1;
                end
                OP_DIV:
                begin
                    if (b == '0)
                    begin
                        dz_next   = 1'b1;
                        done_next = 1'b1;
                    end
                    else
                    begin
                        // Divide magnitudes, fix the sign at the end
                        neg_next  = a[VALUE_W-1] ^ b[VALUE_W-1];
                        acc_next  = a[VALUE_W-1] ? (VALUE_W'(0) - a) : a;
                        aux_next  = b[VALUE_W-1] ? (VALUE_W'(0) - b) : b;
                        base_next = '0;
                        step_next = STEP_W'(DIV_STEPS);
                        busy_next = 1'b1;
                    end
                end
                OP_POW:
                begin
                    acc_next = VALUE_W'(1);
                    if (b[VALUE_W-1] || b == '0)
                    begin
                        done_next = 1'b1;
                    end
                    else
                    begin
                        base_next = a;
                        aux_next  = b;
                        busy_next = 1'b1;
                    end
                end
                default:
                begin
                    acc_next  = '0;
                    done_next = 1'b1;
                end
            endcase
        end
        else if (busy_reg)
        begin
            if (op_reg == OP_DIV)
            begin
                if (step_reg != '0)
                begin
                    // One restoring step: base holds the partial remainder
                    if (!rem_diff[VALUE_W])
                    begin
                        base_next = rem_diff[VALUE_W-1:0];
                        acc_next  = {acc_reg[VALUE_W-2:0], 1'b1};
                    end
                    else
                    begin
                        base_next = rem_sh[VALUE_W-1:0];
                        acc_next  = {acc_reg[VALUE_W-2:0], 1'b0};
                    end
                    step_next = step_reg - STEP_W'(1);
                end
                else
                begin
                    acc_next  = neg_reg ? (VALUE_W'(0) - acc_reg) : acc_reg;
                    done_next = 1'b1;
                    busy_next = 1'b0;
                end
            end
            else
            begin
                if (aux_reg != '0)
                begin
                    if (aux_reg[0])
                    begin
                        acc_next = mul_acc;
                    end
                    base_next = mul_base;
                    aux_next  = aux_reg >> 1;
                end
                else
                begin
                    done_next = 1'b1;
                    busy_next = 1'b0;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            dz_reg   <= 1'b0;
            op_reg   <= OP_NONE;
            step_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            dz_reg   <= dz_next;
            op_reg   <= op_next;
            step_reg <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        neg_reg  <= neg_next;
        acc_reg  <= acc_next;
        base_reg <= base_next;
        aux_reg  <= aux_next;
    end

    assign res.done     = done_reg;
    assign res.div_zero = dz_reg;
    assign res.result   = acc_reg;

endmodule

`default_nettype wire

// ===== rtl/prefix_expression_evaluator_core.sv =====
// ============================================================================
// prefix_expression_evaluator_core: stack evaluator for prefix expressions
// Sequencer around an operand stack memory and an iterative arithmetic unit.
// ============================================================================
// Usage:
//   Slave channel (s_*): one expression character per transfer, the
//   expression's last character first. s_tlast marks the final character
//   (the expression's first); it closes the expression.
//   Master channel (m_*): one transfer per expression, after the final
//   character: value in m_tdata[31:0], status in m_tdata[34:32].
//   Status: 0 ok, 1 too few operands, 2 count not one, 3 divide by zero,
//   4 stack overflow; value is zero whenever status is not ok.
// Steps per character (the stack memory has one read port):
//   digit, ignored character, or operator with an error: taken in the idle state.
//   + - * : accept and read, operand fetch, write back.
//   /     : as above, running the 32-step restoring divider; a zero divisor skips it.
//   ^     : as above, square-and-multiply over the exponent bits if it is above zero.
//   final character: then loads the output register.
// The top of stack lives in a register; the memory supplies the second
// operand. Reset clears the count, the error latch, the state and the
// output valid; the stack memory itself is not cleared.
// A stalled master side holds the result in the output register; the
// slave side keeps taking characters; it stalls while an operator is evaluated
// or a result is loaded, and while the next result waits on the previous one.
// ============================================================================
`default_nettype none

module prefix_expression_evaluator_core
    import pee_pkg::*;
#(
    parameter int STACK_DEPTH = STACK_DEPTH_DEF
)
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    // Slave side
    input  wire logic                   s_tvalid,
    output      logic                   s_tready,
    input  wire logic [CHAR_W-1:0]      s_tdata,   // [7:0] char_code
    input  wire logic                   s_tlast,   // is_last
    // Master side
    output      logic                   m_tvalid,
    input  wire logic                   m_tready,
    output      logic [OUT_TDATA_W-1:0] m_tdata    // [31:0] value, [34:32] status
);

    localparam int ADDR_W = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
    localparam int CNT_W  = $clog2(STACK_DEPTH + 1);

    state_t              state_reg, state_next;
    logic [CNT_W-1:0]    count_reg, count_next;
    logic [STATUS_W-1:0] err_reg, err_next;
    logic [VALUE_W-1:0]  tos_reg, tos_next;
    op_t                 op_reg, op_next;
    logic                last_reg, last_next;
    logic                out_valid_reg, out_valid_next;
    logic [VALUE_W-1:0]  out_value_reg, out_value_next;
    logic [STATUS_W-1:0] out_status_reg, out_status_next;

    op_t                 in_op;
    logic                in_xfer;
    logic                out_free;
    logic                op_go;
    logic [CNT_W-1:0]    cnt_m1;
    logic [CNT_W-1:0]    cnt_m2;

    logic                wr_en;
    logic [ADDR_W-1:0]   wr_addr;
    logic [VALUE_W-1:0]  wr_data;
    logic                rd_en;
    logic [ADDR_W-1:0]   rd_addr;
    logic [VALUE_W-1:0]  rd_data;

    logic                alu_start;
    alu_res_t            alu_res;

    assign in_op    = decode_char(s_tdata);
    assign s_tready = (state_reg == S_IDLE);
    assign in_xfer  = s_tvalid && s_tready;
    assign out_free = !out_valid_reg || m_tready;
    assign cnt_m1   = count_reg - CNT_W'(1);
    assign cnt_m2   = count_reg - CNT_W'(2);

    // Operator with two operands and no error latched: go fetch the second one
    assign op_go = is_binop(in_op) && (err_reg == STAT_OK) && (count_reg >= CNT_W'(2));

    pee_stack_ram #(
        .DEPTH  (STACK_DEPTH),
        .ADDR_W (ADDR_W)
    ) u_stack_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    pee_alu u_alu (
        .clk   (clk),
        .rst_n (rst_n),
        .start (alu_start),
        .op    (op_reg),
        .a     (tos_reg),
        .b     (rd_data),
        .res   (alu_res)
    );

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (s_tvalid)
                begin
                    if (op_go)
                        state_next = S_READ;
                    else if (s_tlast)
                        state_next = S_EMIT;
                end
            end
            S_READ:
            begin
                state_next = S_EXEC;
            end
            S_EXEC:
            begin
                if (alu_res.done)
                    state_next = last_reg ? S_EMIT : S_IDLE;
            end
            S_EMIT:
            begin
                if (out_free)
                    state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Datapath and memory control
    always_comb
    begin
        count_next      = count_reg;
        err_next        = err_reg;
        tos_next        = tos_reg;
        op_next         = op_reg;
        last_next       = last_reg;
        out_value_next  = out_value_reg;
        out_status_next = out_status_reg;
        out_valid_next  = out_valid_reg && !m_tready;

        wr_en     = 1'b0;
        wr_addr   = count_reg[ADDR_W-1:0];
        wr_data   = VALUE_W'(s_tdata - CH_ZERO);
        rd_en     = 1'b0;
        rd_addr   = cnt_m2[ADDR_W-1:0];
        alu_start = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (in_xfer && err_reg == STAT_OK)
                begin
                    if (in_op == OP_DIGIT)
                    begin
                        if (count_reg >= CNT_W'(STACK_DEPTH))
                        begin
                            err_next = STAT_OVERFLOW;
                        end
                        else
                        begin
                            // Push: the new top also lands in the memory
                            wr_en      = 1'b1;
                            tos_next   = wr_data;
                            count_next = count_reg + CNT_W'(1);
                        end
                    end
                    else if (is_binop(in_op))
                    begin
                        if (op_go)
                        begin
                            rd_en     = 1'b1;
                            op_next   = in_op;
                            last_next = s_tlast;
                        end
                        else
                        begin
                            err_next = STAT_FEW;
                        end
                    end
                end
            end
            S_READ:
            begin
                // Second operand is on rd_data now
                alu_start = 1'b1;
            end
            S_EXEC:
            begin
                if (alu_res.done)
                begin
                    if (alu_res.div_zero)
                    begin
                        // Operands are consumed, nothing is pushed
                        err_next   = STAT_DIVZERO;
                        count_next = cnt_m2;
                    end
                    else
                    begin
                        wr_en      = 1'b1;
                        wr_addr    = cnt_m2[ADDR_W-1:0];
                        wr_data    = alu_res.result;
                        tos_next   = alu_res.result;
                        count_next = cnt_m1;
                    end
                end
            end
            S_EMIT:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    if (err_reg != STAT_OK)
                    begin
                        out_status_next = err_reg;
                        out_value_next  = '0;
                    end
                    else if (count_reg != CNT_W'(1))
                    begin
                        out_status_next = STAT_COUNT;
                        out_value_next  = '0;
                    end
                    else
                    begin
                        out_status_next = STAT_OK;
                        out_value_next  = tos_reg;
                    end
                    // Start the next expression from an empty stack
                    count_next = '0;
                    err_next   = STAT_OK;
                end
            end
            default:
            begin
                count_next = count_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            err_reg       <= STAT_OK;
            op_reg        <= OP_NONE;
            last_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            err_reg       <= err_next;
            op_reg        <= op_next;
            last_reg      <= last_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        tos_reg        <= tos_next;
        out_value_reg  <= out_value_next;
        out_status_reg <= out_status_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{OUT_PAD_W{1'b0}}, out_status_reg, out_value_reg};

endmodule

`default_nettype wire

// ===== rtl/pee_checker.sv =====
// ============================================================================
// pee_checker: port-level checks of the prefix expression evaluator
// Watches the slave and master channels and flags results that break the
// block's contract.
// ============================================================================
`default_nettype none

module pee_checker
    import pee_pkg::*;
(
    input wire logic                   clk,
    input wire logic                   rst_n,
    input wire logic                   s_tvalid,
    input wire logic                   s_tready,
    input wire logic [CHAR_W-1:0]      s_tdata,
    input wire logic                   s_tlast,
    input wire logic                   m_tvalid,
    input wire logic                   m_tready,
    input wire logic [OUT_TDATA_W-1:0] m_tdata
);

    // A stalled result holds until taken
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed or dropped while stalled");

    // Only a final character creates a result
    a_no_result_mid: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready && !s_tlast |=> !$rose(m_tvalid))
        else $error("result appeared after a non-final character");

    // Status stays within its codes
    a_status_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> m_tdata[34:32] <= STAT_OVERFLOW)
        else $error("status code out of range");

    // Error results carry a zero value
    a_err_value: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tdata[34:32] != STAT_OK) |-> m_tdata[31:0] == '0)
        else $error("nonzero value with error status");

    // Characters offered on the slave side carry known data and last flags
    a_char_known: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid |-> !$isunknown(s_tdata) && !$isunknown(s_tlast))
        else $error("unknown character on the slave side");

endmodule

bind prefix_expression_evaluator_core pee_checker u_pee_checker (.*);

`default_nettype wire
